// File: design/tce_pkg.sv
// TCP connection engine package: widths, codes, per-socket record type.
// No dependencies.
`timescale 1ns / 1ps
package tce_pkg;
  localparam int Sockets = 4;
  localparam int SockW = 2;
  localparam int SendBytes = 1024;
  localparam int RecvBytes = 1024;

  localparam logic [7:0] FlFin = 8'h01;
  localparam logic [7:0] FlSyn = 8'h02;
  localparam logic [7:0] FlRst = 8'h04;
  localparam logic [7:0] FlPsh = 8'h08;
  localparam logic [7:0] FlAck = 8'h10;

  localparam logic [2:0] StClose = 3'd0;
  localparam logic [2:0] StListen = 3'd1;
  localparam logic [2:0] StSynSent = 3'd2;
  localparam logic [2:0] StSynRecv = 3'd3;
  localparam logic [2:0] StEstab = 3'd4;
  localparam logic [2:0] StCloseWait = 3'd5;
  localparam logic [2:0] StLastAck = 3'd6;

  localparam logic [2:0] KSeg = 3'd0;
  localparam logic [2:0] KOpen = 3'd1;
  localparam logic [2:0] KListen = 3'd2;
  localparam logic [2:0] KClose = 3'd3;
  localparam logic [2:0] KWrite = 3'd4;
  localparam logic [2:0] KRead = 3'd5;
  localparam logic [2:0] KPoll = 3'd6;
  localparam logic [2:0] KIgnored = 3'd7;

  localparam logic [1:0] CfgLocalIp = 2'd0;
  localparam logic [1:0] CfgRecvWin = 2'd1;
  localparam logic [1:0] CfgPush = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  socket_index;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [7:0]  tcp_flags;
    logic [10:0] payload_len;
    logic [31:0] initial_seq;
  } item_t;

  typedef struct packed {
    logic [31:0] out_dest_ip;
    logic [15:0] out_sport;
    logic [15:0] out_dport;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [7:0]  out_flags;
    logic [15:0] out_window;
    logic [9:0]  send_offset;
    logic [10:0] send_len;
    logic [10:0] delivered_len;
    logic [2:0]  out_socket;
    logic [2:0]  socket_state;
  } result_t;

  typedef struct packed {
    logic        used;
    logic [2:0]  st;
    logic [15:0] own_port;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [31:0] recv_next;
    logic [31:0] snd_una;
    logic [31:0] syn_seq;
    logic [9:0]  snd_start;
    logic [10:0] snd_queued;
    logic        unsent;
    logic [10:0] recv_used;
  } sock_t;
endpackage

// File: design/tce_if.sv
// Valid/ready channel interfaces for items and results.
// Depends on tce_pkg.
`timescale 1ns / 1ps
interface tce_item_if;
  logic valid;
  logic ready;
  tce_pkg::item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tce_result_if;
  logic valid;
  logic ready;
  tce_pkg::result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: design/tcp_connection_engine_top.sv
// Top level of the TCP connection engine: socket table, shared 32-bit
// adder/comparator under a sequencer, output register. Depends on tce_pkg, tce_if.
//
// A segment passes the accept step, a scan (S_SCAN) that tests one slot per
// step, the compare steps S_CMP1, S_CMP2 and S_OUT in which the shared 32-bit
// comparator checks the sequence number against recv_next and the window end (the
// ack against snd_una in SYN_SENT), and the update step S_EXEC that rewrites the
// slot and loads the result register. Commands skip scan and compare and go
// straight from accept to update; kind seven is dropped at accept. The update
// step waits while an earlier result is still held, and the input stays not
// ready meanwhile.
`timescale 1ns / 1ps
module tcp_connection_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  tce_item_if.sink    in_if,
  tce_result_if.source out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CMP1, S_CMP2, S_EXEC, S_OUT} state_e;

  state_e st_q;
  tce_pkg::item_t it_q;
  tce_pkg::sock_t tab_q [tce_pkg::Sockets];
  tce_pkg::sock_t sk;
  logic [1:0] sc_q;
  logic found_q;
  logic [1:0] hit_q;
  logic [31:0] a_q, b_q;
  logic lt_q, gt_q;
  logic [31:0] lo_ip_q;
  logic [15:0] win_q;
  logic push_q;
  logic [32:0] cmp_diff;
  logic match;

  // shared compare unit: a - b
  assign cmp_diff = {1'b0, a_q} - {1'b0, b_q};
  assign sk = tab_q[hit_q];
  assign match = tab_q[sc_q].used && tab_q[sc_q].own_port == it_q.dst_port &&
                 (tab_q[sc_q].peer_ip == '0 || (tab_q[sc_q].peer_ip == it_q.src_ip &&
                  tab_q[sc_q].peer_port == it_q.src_port));

  assign in_if.ready = (st_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_ip_q <= '0;
      win_q   <= 16'd1024;
      push_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tce_pkg::CfgLocalIp: lo_ip_q <= cfg_data_i;
        tce_pkg::CfgRecvWin: win_q <= cfg_data_i[15:0];
        tce_pkg::CfgPush: push_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  function automatic tce_pkg::result_t fill(tce_pkg::sock_t s, logic [1:0] i,
                                            logic [7:0] fl);
    tce_pkg::result_t r;
    r = '0;
    r.out_dest_ip = s.peer_ip;
    r.out_sport = s.own_port;
    r.out_dport = s.peer_port;
    r.out_seq = s.snd_una + ((s.syn_seq == s.snd_una) ? 32'd1 : 32'd0);
    r.out_ack = s.recv_next;
    r.out_flags = fl;
    r.out_window = 16'(tce_pkg::RecvBytes) - {5'd0, s.recv_used};
    r.out_socket = {1'b0, i};
    r.socket_state = s.st;
    return r;
  endfunction

  // next slot content and result for the exec step
  tce_pkg::sock_t ns;
  tce_pkg::result_t res;
  logic emit;
  always_comb begin
    logic [7:0] fl;
    logic f_fin, f_syn, f_rst, f_ack;
    logic [31:0] seglen, d;
    logic [10:0] c, room, take, n, fr;
    logic [10:0] stsum;
    ns = sk;
    res = '0;
    emit = 1'b0;
    fl = it_q.tcp_flags;
    f_fin = (fl & tce_pkg::FlFin) != 8'h00;
    f_syn = (fl & tce_pkg::FlSyn) != 8'h00;
    f_rst = (fl & tce_pkg::FlRst) != 8'h00;
    f_ack = (fl & tce_pkg::FlAck) != 8'h00;
    seglen = {21'd0, it_q.payload_len} + ((f_syn || f_fin) ? 32'd1 : 32'd0);
    n = it_q.payload_len;
    d = 32'd0; c = '0; room = '0; take = '0; fr = '0; stsum = '0;
    if (it_q.kind == tce_pkg::KSeg) begin
      if (!found_q) begin
        if (!f_rst) begin
          emit = 1'b1;
          res.out_dest_ip = it_q.src_ip;
          res.out_sport = it_q.dst_port;
          res.out_dport = it_q.src_port;
          res.out_ack = it_q.seq_num + 32'd1;
          res.out_flags = tce_pkg::FlRst | tce_pkg::FlAck;
          res.out_socket = 3'd4;
        end
      end else if (sk.st == tce_pkg::StListen) begin
        if (!f_rst && f_ack) begin
          emit = 1'b1;
          res = fill(sk, hit_q, tce_pkg::FlRst);
          res.out_dest_ip = it_q.src_ip;
          res.out_dport = it_q.src_port;
          res.out_seq = it_q.ack_num;
        end else if (!f_rst && f_syn) begin
          ns.recv_next = it_q.seq_num + 32'd1;
          ns.snd_una = it_q.initial_seq;
          ns.syn_seq = it_q.initial_seq;
          ns.peer_ip = it_q.src_ip;
          ns.peer_port = it_q.src_port;
          ns.st = tce_pkg::StSynRecv;
          emit = 1'b1;
          res = fill(ns, hit_q, tce_pkg::FlSyn | tce_pkg::FlAck);
          res.out_seq = it_q.initial_seq;
        end
      end else if (sk.st == tce_pkg::StSynSent) begin
        // lt_q here: ack < snd_una
        if (f_ack && !lt_q) begin
          if (!f_rst) begin
            emit = 1'b1;
            res = fill(sk, hit_q, tce_pkg::FlRst);
            res.out_seq = it_q.ack_num;
          end
        end else if (f_rst) ns.st = tce_pkg::StClose;
      end else if ((lt_q || gt_q) && !f_rst) begin
        emit = 1'b1;
        res = fill(sk, hit_q, tce_pkg::FlAck);
      end else if (f_rst) begin
        if (sk.st == tce_pkg::StSynRecv) begin
          ns.peer_ip = '0; ns.peer_port = '0; ns.st = tce_pkg::StListen;
        end else ns.st = tce_pkg::StClose;
      end else if (f_syn) begin
        emit = 1'b1;
        res = fill(sk, hit_q, tce_pkg::FlRst);
        res.out_seq = it_q.ack_num;
      end else if (f_ack) begin
        if (sk.st == tce_pkg::StLastAck) begin
          ns.st = tce_pkg::StClose;
        end else begin
          if (sk.st == tce_pkg::StSynRecv) begin
            ns.st = tce_pkg::StEstab;
            ns.snd_una = sk.snd_una + 32'd1;
          end else if (sk.st == tce_pkg::StEstab) begin
            d = it_q.ack_num - sk.snd_una;
            if (d <= {21'd0, sk.snd_queued}) begin
              stsum = {1'b0, sk.snd_start} + d[10:0];
              ns.snd_start = stsum[9:0];
              ns.snd_queued = sk.snd_queued - d[10:0];
            end
            ns.snd_una = it_q.ack_num;
          end
          if (f_fin) begin
            ns.recv_next = it_q.seq_num + seglen;
            if (ns.st == tce_pkg::StSynRecv || ns.st == tce_pkg::StEstab)
              ns.st = tce_pkg::StCloseWait;
            emit = 1'b1;
            res = fill(ns, hit_q, tce_pkg::FlAck);
          end else begin
            room = 11'(tce_pkg::SendBytes) - {1'b0, ns.snd_start};
            c = (ns.snd_queued < room) ? ns.snd_queued : room;
            if (!(seglen == 0 && c == 0)) begin
              ns.recv_next = it_q.seq_num + seglen;
              ns.unsent = 1'b0;
              fr = 11'(tce_pkg::RecvBytes) - ns.recv_used;
              take = (it_q.payload_len < fr) ? it_q.payload_len : fr;
              ns.recv_used = ns.recv_used + take;
              emit = 1'b1;
              res = fill(ns, hit_q, tce_pkg::FlAck |
                         ((c != 0 && push_q) ? tce_pkg::FlPsh : 8'h00));
              res.send_offset = (c != 0) ? ns.snd_start : 10'd0;
              res.send_len = c;
              res.delivered_len = take;
            end
          end
        end
      end
    end else if (it_q.kind == tce_pkg::KOpen) begin
      ns = '0;
      ns.used = 1'b1;
      ns.own_port = it_q.dst_port;
    end else if (sk.used) begin
      case (it_q.kind)
        tce_pkg::KListen: begin
          ns.peer_ip = '0; ns.peer_port = '0; ns.st = tce_pkg::StListen;
        end
        tce_pkg::KClose: begin
          stsum = {1'b0, sk.snd_start} + sk.snd_queued;
          ns.snd_start = stsum[9:0];
          ns.snd_queued = '0;
          ns.unsent = 1'b0;
          if (sk.st == tce_pkg::StCloseWait) begin
            ns.st = tce_pkg::StLastAck;
            emit = 1'b1;
            res = fill(ns, hit_q, tce_pkg::FlFin | tce_pkg::FlAck);
          end
        end
        tce_pkg::KWrite: begin
          room = 11'(tce_pkg::SendBytes) - sk.snd_queued;
          if (n > room) n = room;
          ns.snd_queued = sk.snd_queued + n;
          if (n != 0) ns.unsent = 1'b1;
        end
        tce_pkg::KRead: begin
          ns.recv_used = sk.recv_used - ((n < sk.recv_used) ? n : sk.recv_used);
        end
        tce_pkg::KPoll: begin
          if (sk.unsent) begin
            ns.unsent = 1'b0;
            room = 11'(tce_pkg::SendBytes) - {1'b0, sk.snd_start};
            c = (sk.snd_queued < room) ? sk.snd_queued : room;
            if ((sk.st == tce_pkg::StEstab || sk.st == tce_pkg::StCloseWait) && c != 0) begin
              emit = 1'b1;
              res = fill(ns, hit_q, tce_pkg::FlAck | (push_q ? tce_pkg::FlPsh : 8'h00));
              res.send_offset = sk.snd_start;
              res.send_len = c;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      out_if.valid <= 1'b0;
      out_if.data <= '0;
      it_q <= '0;
      sc_q <= '0; found_q <= 1'b0; hit_q <= '0;
      a_q <= '0; b_q <= '0; lt_q <= 1'b0; gt_q <= 1'b0;
      for (int i = 0; i < tce_pkg::Sockets; i++) tab_q[i] <= '0;
    end else begin
      if (st_q == S_EXEC && (!out_if.valid || out_if.ready) && emit) begin
        out_if.valid <= 1'b1;
      end else if (out_if.ready) begin
        out_if.valid <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: if (in_if.valid) begin
          it_q <= in_if.data;
          sc_q <= '0; found_q <= 1'b0;
          hit_q <= in_if.data.socket_index;
          st_q <= (in_if.data.kind == tce_pkg::KSeg) ? S_SCAN :
                  (in_if.data.kind == tce_pkg::KIgnored) ? S_IDLE : S_EXEC;
        end
        S_SCAN: begin
          if (match && !found_q) begin
            found_q <= 1'b1; hit_q <= sc_q;
          end
          sc_q <= sc_q + 2'd1;
          if (sc_q == 2'(tce_pkg::Sockets - 1)) st_q <= S_CMP1;
        end
        S_CMP1: begin
          // SYN_SENT wants ack < snd_una, others seq < recv_next
          if (sk.st == tce_pkg::StSynSent) begin
            a_q <= it_q.ack_num; b_q <= sk.snd_una;
          end else begin
            a_q <= it_q.seq_num; b_q <= sk.recv_next;
          end
          st_q <= S_CMP2;
        end
        S_CMP2: begin
          lt_q <= cmp_diff[32];
          a_q <= sk.recv_next + {16'd0, win_q};
          b_q <= it_q.seq_num;
          st_q <= S_OUT;
        end
        S_OUT: begin
          gt_q <= cmp_diff[32];
          st_q <= S_EXEC;
        end
        S_EXEC: if (!out_if.valid || out_if.ready) begin
          if (it_q.kind != tce_pkg::KSeg || found_q) tab_q[hit_q] <= ns;
          if (emit) out_if.data <= res;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> st_q == S_IDLE) else $error("ready outside idle");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> out_if.valid) else $error("result dropped");
  a_nosock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.data.out_socket == 3'd4) |->
    out_if.data.out_flags == (tce_pkg::FlRst | tce_pkg::FlAck)) else $error("bad nomatch");
endmodule
